/* src/sorted_joint_pose_table_defines.svh */
// Assertion macros shared by the sorted joint pose table RTL.
`ifndef SORTED_JOINT_POSE_TABLE_DEFINES_SVH
`define SORTED_JOINT_POSE_TABLE_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define SJPT_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define SJPT_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* src/sjpt_pkg.sv */
// Shared types and constants of the sorted joint pose table.
`timescale 1ns / 1ps
package sjpt_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int KEY_BITS_DEF    = 8;

	localparam int WORD_W = 32;
	localparam int VEC_W  = 4 * WORD_W;

	// Input tdata layout, lowest bit first.
	localparam int IN_OP_LSB  = 0;
	localparam int IN_KEY_LSB = 2;
	localparam int IN_KEY_W   = 8;
	localparam int IN_VEC_LSB = 10;
	localparam int IN_DATA_W  = 144;

	// Output tdata layout, lowest bit first.
	localparam int OUT_VEC_LSB = 2;
	localparam int OUT_DATA_W  = 136;
	localparam int OUT_PAD_W   = OUT_DATA_W - OUT_VEC_LSB - VEC_W;

	typedef enum logic [1:0] {
		OP_WR_OFF = 2'd0,
		OP_WR_ORI = 2'd1,
		OP_RD_OFF = 2'd2,
		OP_RD_ORI = 2'd3
	} op_t;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	// Command broadcast from the sequencer to every cell of the row.
	typedef struct packed {
		logic cmp_en;
		logic apply_en;
		op_t  op;
		logic hit;
		logic full;
	} cell_cmd_t;

	function automatic logic is_write(input op_t op);
		return (op == OP_WR_OFF) || (op == OP_WR_ORI);
	endfunction

endpackage

/* src/sjpt_cell.sv */
// One table slot: holds a key and both vectors, compares and shifts toward its upper neighbor.
`timescale 1ns / 1ps
module sjpt_cell import sjpt_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_cmd_t           cmd,
	input  logic [KEY_BITS-1:0] key,
	input  logic [VEC_W-1:0]    wvec,
	input  logic                left_valid,
	input  logic [KEY_BITS-1:0] left_key,
	input  logic [VEC_W-1:0]    left_off,
	input  logic [VEC_W-1:0]    left_ori,
	input  logic                left_gt,
	output logic                valid,
	output logic [KEY_BITS-1:0] key_out,
	output logic [VEC_W-1:0]    off,
	output logic [VEC_W-1:0]    ori,
	output logic                gt,
	output logic                match,
	output logic [VEC_W-1:0]    rd_vec
);

	logic                valid_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VEC_W-1:0]    off_q;
	logic [VEC_W-1:0]    ori_q;
	logic                match_q;
	logic                gt_q;

	logic                valid_d;
	logic [KEY_BITS-1:0] key_d;
	logic [VEC_W-1:0]    off_d;
	logic [VEC_W-1:0]    ori_d;
	logic                sel_off;

	assign sel_off = (cmd.op == OP_WR_OFF);

	// A cell whose key is above the new key, or that is empty, moves up on an insert.
	// The lowest such cell takes the new entry.
	always_comb begin
		valid_d = valid_q;
		key_d   = key_q;
		off_d   = off_q;
		ori_d   = ori_q;
		if (cmd.apply_en && is_write(cmd.op)) begin
			if (cmd.hit) begin
				if (match_q) begin
					if (sel_off) begin
						off_d = wvec;
					end else begin
						ori_d = wvec;
					end
				end
			end else if (!cmd.full && gt_q) begin
				if (left_gt) begin
					valid_d = left_valid;
					key_d   = left_key;
					off_d   = left_off;
					ori_d   = left_ori;
				end else begin
					valid_d = 1'b1;
					key_d   = key;
					off_d   = sel_off ? wvec : '0;
					ori_d   = sel_off ? '0 : wvec;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
			gt_q    <= 1'b0;
		end else begin
			valid_q <= valid_d;
			if (cmd.cmp_en) begin
				match_q <= valid_q && (key_q == key);
				gt_q    <= !valid_q || (key_q > key);
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		off_q <= off_d;
		ori_q <= ori_d;
	end

	assign valid   = valid_q;
	assign key_out = key_q;
	assign off     = off_q;
	assign ori     = ori_q;
	assign gt      = gt_q;
	assign match   = match_q;
	assign rd_vec  = (match_q && !is_write(cmd.op)) ?
		((cmd.op == OP_RD_OFF) ? off_q : ori_q) : '0;

endmodule

/* src/sorted_joint_pose_table.sv */
// Top level of the sorted joint pose table: sequencer, cell row and output register.
`timescale 1ns / 1ps
// A request is held in the request register, compared in the compare cycle and written, with its result,
// into the output register at the end of the apply cycle. One request is in the row at a time.
// The next input transfer is taken in the apply cycle, as soon as the output register can take
// the result. Reset clears the valid bit of every cell, the sequencer and the output valid.
// Stored keys and vectors are not cleared and need no clearing pass after reset.
`include "sorted_joint_pose_table_defines.svh"
module sorted_joint_pose_table import sjpt_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// operation[1:0], joint_key[9:2], value_x[41:10], value_y[73:42],
	// value_z[105:74], value_w[137:106], zero padding above
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// result_status[1:0], read_x[33:2], read_y[65:34], read_z[97:66],
	// read_w[129:98], zero padding above
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// The sequencer walks each request through a compare cycle and an apply cycle.
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CMP   = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VEC_W-1:0]    wvec_q;

	logic                out_valid_q;
	logic [1:0]          out_status_q;
	logic [VEC_W-1:0]    out_vec_q;

	logic                in_xfer;
	logic                apply_go;
	logic                hit;
	logic                full;
	logic [1:0]          status;
	logic [VEC_W-1:0]    rd_any;
	cell_cmd_t           cmd;

	logic [MAX_ENTRIES-1:0] valid_vec;
	logic [MAX_ENTRIES-1:0] gt_vec;
	logic [MAX_ENTRIES-1:0] match_vec;
	logic [KEY_BITS-1:0]    cell_key [MAX_ENTRIES];
	logic [VEC_W-1:0]       cell_off [MAX_ENTRIES];
	logic [VEC_W-1:0]       cell_ori [MAX_ENTRIES];
	logic [VEC_W-1:0]       cell_rd  [MAX_ENTRIES];

	// The apply cycle may only finish when the output register is free or being emptied.
	assign apply_go      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) || ((state_q == ST_APPLY) && apply_go);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (apply_go) begin
						state_q <= in_xfer ? ST_CMP : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request register. Only the low KEY_BITS bits of the key take part in the search.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q   <= op_t'(s_axis_tdata[IN_OP_LSB +: 2]);
			key_q  <= KEY_BITS'(s_axis_tdata[IN_KEY_LSB +: IN_KEY_W]);
			wvec_q <= s_axis_tdata[IN_VEC_LSB +: VEC_W];
		end
	end

	// Occupied cells always form a contiguous run from cell zero, so the top cell tells
	// whether the table is full.
	assign hit  = |match_vec;
	assign full = valid_vec[MAX_ENTRIES-1];

	always_comb begin
		cmd.cmp_en   = (state_q == ST_CMP);
		cmd.apply_en = (state_q == ST_APPLY) && apply_go;
		cmd.op       = op_q;
		cmd.hit      = hit;
		cmd.full     = full;
	end

	// The row of cells. Each cell sees its lower neighbor so that an insert shifts
	// every larger entry up by one slot in the apply cycle.
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic                l_valid;
		logic [KEY_BITS-1:0] l_key;
		logic [VEC_W-1:0]    l_off;
		logic [VEC_W-1:0]    l_ori;
		logic                l_gt;

		if (i == 0) begin : g_first
			assign l_valid = 1'b0;
			assign l_key   = '0;
			assign l_off   = '0;
			assign l_ori   = '0;
			assign l_gt    = 1'b0;
		end else begin : g_rest
			assign l_valid = valid_vec[i-1];
			assign l_key   = cell_key[i-1];
			assign l_off   = cell_off[i-1];
			assign l_ori   = cell_ori[i-1];
			assign l_gt    = gt_vec[i-1];
		end

		sjpt_cell #(
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.key        (key_q),
			.wvec       (wvec_q),
			.left_valid (l_valid),
			.left_key   (l_key),
			.left_off   (l_off),
			.left_ori   (l_ori),
			.left_gt    (l_gt),
			.valid      (valid_vec[i]),
			.key_out    (cell_key[i]),
			.off        (cell_off[i]),
			.ori        (cell_ori[i]),
			.gt         (gt_vec[i]),
			.match      (match_vec[i]),
			.rd_vec     (cell_rd[i])
		);
	end

	// At most one cell matches, so the read data is the OR over the row.
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			rd_any = rd_any | cell_rd[i];
		end
	end

	always_comb begin
		if (is_write(op_q)) begin
			status = (!hit && full) ? STATUS_FULL : STATUS_OK;
		end else begin
			status = hit ? STATUS_OK : STATUS_MISS;
		end
	end

	// Output register; it parts the row from the downstream side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.apply_en) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply_en) begin
			out_status_q <= status;
			out_vec_q    <= rd_any;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_vec_q, out_status_q};

	`SJPT_ASSERT_ALWAYS(a_valid_contiguous,
		(valid_vec & (valid_vec + MAX_ENTRIES'(1))) == '0,
		"occupied cells are not a contiguous run from cell zero")
	`SJPT_ASSERT_IMPLY(a_match_single, state_q == ST_APPLY, $onehot0(match_vec),
		"more than one cell matches the key")
	`SJPT_ASSERT_IMPLY(a_gt_monotone, state_q == ST_APPLY,
		((~gt_vec) & ((~gt_vec) + MAX_ENTRIES'(1))) == '0,
		"greater flags are not monotone along the row")
	`SJPT_ASSERT_IMPLY(a_result_from_apply, $rose(out_valid_q), $past(state_q == ST_APPLY),
		"result appeared outside an apply cycle")

endmodule
